// ===== hdl/ematod_pkg.sv =====
// Shared constants for the EMA tap and occupancy detector.
// Register indexes, field widths and configuration reset values.
// No dependencies.
package ematod_pkg;

    localparam int unsigned FORCE_W   = 18;
    localparam int unsigned FACTOR_W  = 16;
    localparam int unsigned TICKS_W   = 32;
    localparam int unsigned ACC_W     = 34;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AVERAGE_FACTOR      = 3'd0,
        REG_TAP_THRESHOLD       = 3'd1,
        REG_DEBOUNCE_TICKS      = 3'd2,
        REG_TAP_WINDOW_TICKS    = 3'd3,
        REG_OCCUPANCY_THRESHOLD = 3'd4
    } t_cfg_reg;

    localparam logic [FACTOR_W-1:0] RST_AVERAGE_FACTOR      = 16'd6554;
    localparam logic [FORCE_W-1:0]  RST_TAP_THRESHOLD       = 18'd1600;
    localparam logic [TICKS_W-1:0]  RST_DEBOUNCE_TICKS      = 32'd20;
    localparam logic [TICKS_W-1:0]  RST_TAP_WINDOW_TICKS    = 32'd200;
    localparam logic [FORCE_W-1:0]  RST_OCCUPANCY_THRESHOLD = 18'd16000;

    // Unity weight in Q0.16, one bit wider than the factor.
    localparam logic [FACTOR_W:0] ONE_Q16 = 17'h10000;

endpackage

// ===== hdl/ema_tap_and_occupancy_detector_core.sv =====
// Top level of the EMA tap and occupancy detector.
// Moving average, tap debounce, tap stamp ring and occupancy tracking.
// Depends on ematod_pkg.
//
//  Channel   Handshake                      Payload
//  -------   ----------------------------   ----------------------------------------
//  input     i_in_valid / o_in_ready        i_kind, i_force_req, i_now_ticks
//  output    o_out_valid / i_out_ready      o_tap_detected, o_help_event, o_occupied,
//                                           o_occupancy_changed, o_average_force
//  config    i_cfg_we                       i_cfg_index, i_cfg_data
//
// One word is accepted per cycle; its result appears in the result register on the
// next cycle. The path is the average multiply-add followed by the tap compare.
// A word is accepted whenever the result register is empty or is being taken in the
// same cycle, so a stalled output holds only one result.
// Reset is synchronous and active low; it restores the register defaults and clears
// the average, the tap history and the result register.
module ema_tap_and_occupancy_detector_core
    import ematod_pkg::*;
#(
    parameter int unsigned NUM_TAPS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [FORCE_W-1:0]    i_force_req,
    input  logic [TICKS_W-1:0]    i_now_ticks,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_tap_detected,
    output logic                  o_help_event,
    output logic                  o_occupied,
    output logic                  o_occupancy_changed,
    output logic [FORCE_W-1:0]    o_average_force,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W  = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int unsigned FILL_W = $clog2(NUM_TAPS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_TAPS - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(NUM_TAPS);

    // Configuration registers.
    logic [FACTOR_W-1:0] r_average_factor;
    logic [FORCE_W-1:0]  r_tap_threshold;
    logic [TICKS_W-1:0]  r_debounce_ticks;
    logic [TICKS_W-1:0]  r_tap_window_ticks;
    logic [FORCE_W-1:0]  r_occupancy_threshold;

    // Detector state.
    logic [ACC_W-1:0]    r_acc,       n_acc;
    logic                r_primed,    n_primed;
    logic                r_occ_flag,  n_occ_flag;
    logic [TICKS_W-1:0]  r_last_tap,  n_last_tap;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic [IDX_W-1:0]    r_widx,      n_widx;
    logic [TICKS_W-1:0]  r_stamps [NUM_TAPS];

    // Result register.
    logic                r_out_valid;
    logic                r_tap,     n_tap;
    logic                r_help,    n_help;
    logic                r_changed, n_changed;
    logic [FORCE_W-1:0]  r_avg_out;

    logic                w_accept;
    logic [ACC_W-1:0]    w_f20;
    logic [ACC_W-1:0]    w_prod_new;
    logic [FACTOR_W:0]   w_keep;
    logic [ACC_W+FACTOR_W:0] w_prod_old;
    logic [ACC_W:0]      w_blend;
    logic [ACC_W-1:0]    w_acc_upd;
    logic [ACC_W:0]      w_rise;
    logic                w_is_rise;
    logic                w_debounced;
    logic [IDX_W-1:0]    w_widx_inc;
    logic [FILL_W-1:0]   w_fill_inc;
    logic [TICKS_W-1:0]  w_span;
    logic                w_stamp_we;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // New average: a*force + floor((1 - a) * acc), everything in Q18.16.
    assign w_f20      = {i_force_req, 16'b0};
    assign w_prod_new = ACC_W'(r_average_factor) * ACC_W'(i_force_req);
    assign w_keep     = ONE_Q16 - {1'b0, r_average_factor};
    assign w_prod_old = w_keep * r_acc;
    assign w_blend    = {1'b0, w_prod_new} + w_prod_old[ACC_W+FACTOR_W:FACTOR_W];
    assign w_acc_upd  = w_blend[ACC_W-1:0];

    assign w_rise      = {1'b0, w_f20} - {1'b0, w_acc_upd};
    assign w_is_rise   = !w_rise[ACC_W] &&
                         (w_rise[ACC_W-1:0] >= {r_tap_threshold, 16'b0});
    assign w_debounced = (i_now_ticks - r_last_tap) >= r_debounce_ticks;

    assign w_widx_inc = (r_widx >= LAST_IDX) ? '0 : r_widx + 1'b1;
    assign w_fill_inc = (r_fill < FULL_FILL) ? r_fill + 1'b1 : r_fill;
    // The oldest stamp sits in the slot after the one just written.
    assign w_span     = i_now_ticks - r_stamps[w_widx_inc];

    always_comb begin
        n_acc      = r_acc;
        n_primed   = r_primed;
        n_occ_flag = r_occ_flag;
        n_last_tap = r_last_tap;
        n_fill     = r_fill;
        n_widx     = r_widx;
        n_tap      = 1'b0;
        n_help     = 1'b0;
        n_changed  = 1'b0;
        w_stamp_we = 1'b0;
        if (!i_kind) begin
            if (!r_primed) begin
                n_acc      = w_f20;
                n_primed   = 1'b1;
                n_occ_flag = i_force_req >= r_occupancy_threshold;
            end else begin
                n_acc = w_acc_upd;
                if (w_is_rise && w_debounced) begin
                    n_tap      = 1'b1;
                    n_last_tap = i_now_ticks;
                    w_stamp_we = 1'b1;
                    n_widx     = w_widx_inc;
                    n_fill     = w_fill_inc;
                    if (w_fill_inc == FULL_FILL && w_span <= r_tap_window_ticks) begin
                        n_help = 1'b1;
                        n_fill = '0;
                        n_widx = '0;
                    end
                end
            end
        end else if (r_primed) begin
            n_occ_flag = r_acc[ACC_W-1:16] >= r_occupancy_threshold;
            n_changed  = n_occ_flag != r_occ_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average_factor      <= RST_AVERAGE_FACTOR;
            r_tap_threshold       <= RST_TAP_THRESHOLD;
            r_debounce_ticks      <= RST_DEBOUNCE_TICKS;
            r_tap_window_ticks    <= RST_TAP_WINDOW_TICKS;
            r_occupancy_threshold <= RST_OCCUPANCY_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_AVERAGE_FACTOR:      r_average_factor      <= i_cfg_data[FACTOR_W-1:0];
                REG_TAP_THRESHOLD:       r_tap_threshold       <= i_cfg_data[FORCE_W-1:0];
                REG_DEBOUNCE_TICKS:      r_debounce_ticks      <= i_cfg_data;
                REG_TAP_WINDOW_TICKS:    r_tap_window_ticks    <= i_cfg_data;
                REG_OCCUPANCY_THRESHOLD: r_occupancy_threshold <= i_cfg_data[FORCE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_primed    <= 1'b0;
            r_occ_flag  <= 1'b0;
            r_last_tap  <= '0;
            r_fill      <= '0;
            r_widx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_acc       <= n_acc;
                r_primed    <= n_primed;
                r_occ_flag  <= n_occ_flag;
                r_last_tap  <= n_last_tap;
                r_fill      <= n_fill;
                r_widx      <= n_widx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tap     <= n_tap;
            r_help    <= n_help;
            r_changed <= n_changed;
            r_avg_out <= n_acc[ACC_W-1:16];
            if (w_stamp_we) begin
                r_stamps[r_widx] <= i_now_ticks;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_tap_detected      = r_tap;
    assign o_help_event        = r_help;
    assign o_occupied          = r_occ_flag;
    assign o_occupancy_changed = r_changed;
    assign o_average_force     = r_avg_out;

    // A help event is only raised by a sample that is itself a tap.
    a_help_needs_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_help) |-> r_tap)
        else $error("help event without tap");

    // Taps come from samples and flag changes from checks, never both.
    a_tap_or_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_tap && r_changed))
        else $error("tap and occupancy change in one result");

    // The stamp ring never claims more entries than it holds.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("tap fill count overflow");

    // A help event empties the ring.
    a_help_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_help) |=> (r_fill == '0 && r_widx == '0))
        else $error("ring not emptied after help event");

    // Until the first sample the average stays at zero.
    a_unprimed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_primed |-> (r_acc == '0 && !r_occ_flag))
        else $error("state moved before first sample");

endmodule

// ===== sim/ematod_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the EMA tap and occupancy detector, plus the small package of item kinds
// shared with the testbench top. It predicts every result word and compares it with the
// output. Depends on ematod_pkg.

package ematod_tb_pkg;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CHECK  = 1'b1
    } t_item_kind;

endpackage

module ematod_checker
    import ematod_pkg::*;
    import ematod_tb_pkg::*;
#(
    parameter int unsigned NUM_TAPS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_kind,
    input  logic [FORCE_W-1:0]    i_force_req,
    input  logic [TICKS_W-1:0]    i_now_ticks,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_tap_detected,
    input  logic                  i_help_event,
    input  logic                  i_occupied,
    input  logic                  i_occupancy_changed,
    input  logic [FORCE_W-1:0]    i_average_force,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]           o_pending,
    output logic [31:0]           o_mismatches
);

    typedef struct packed {
        logic               tap;
        logic               help;
        logic               occupied;
        logic               changed;
        logic [FORCE_W-1:0] average;
    } t_detector_word;

    logic [FACTOR_W-1:0] factor_q;
    logic [FORCE_W-1:0]  tap_thr_q;
    logic [TICKS_W-1:0]  debounce_q;
    logic [TICKS_W-1:0]  window_q;
    logic [FORCE_W-1:0]  occ_thr_q;

    logic [ACC_W-1:0]    avg_acc;
    logic                primed;
    logic                occ_flag;
    logic [TICKS_W-1:0]  last_tap;
    logic [TICKS_W-1:0]  tap_ring [NUM_TAPS];
    logic [4:0]          ring_fill;
    logic [3:0]          ring_wr;

    t_detector_word      expected_words [$];
    int unsigned         mismatch_count = 0;

    // Stores a tap stamp in the ring and reports whether the help event fires.
    function automatic logic log_tap(input logic [TICKS_W-1:0] stamp);
        logic [3:0] slot;
        slot = (ring_wr >= NUM_TAPS) ? 4'd0 : ring_wr;
        tap_ring[slot] = stamp;
        slot = slot + 4'd1;
        if (slot >= NUM_TAPS) begin
            slot = 4'd0;
        end
        ring_wr = slot;
        if (ring_fill < NUM_TAPS) begin
            ring_fill = ring_fill + 5'd1;
        end
        // The slot about to be overwritten holds the oldest of the last taps.
        if (ring_fill >= NUM_TAPS && (stamp - tap_ring[slot]) <= window_q) begin
            ring_fill = '0;
            ring_wr = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_detector_word predict_detector(input logic kind,
                                                        input logic [FORCE_W-1:0] force_val,
                                                        input logic [TICKS_W-1:0] now);
        t_detector_word word;
        logic [ACC_W-1:0] f20;
        logic [63:0]      blend;
        logic             occ_now;
        word = '0;
        f20 = {force_val, 16'h0};
        if (kind == KIND_SAMPLE) begin
            if (!primed) begin
                avg_acc = f20;
                primed = 1'b1;
                occ_flag = (avg_acc >= {occ_thr_q, 16'h0});
            end else begin
                blend = 64'(factor_q) * 64'(f20)
                      + (64'(ONE_Q16) - 64'(factor_q)) * 64'(avg_acc);
                avg_acc = blend[ACC_W+15:16];
                if (f20 >= avg_acc && (f20 - avg_acc) >= {tap_thr_q, 16'h0}) begin
                    if ((now - last_tap) >= debounce_q) begin
                        word.tap = 1'b1;
                        last_tap = now;
                        word.help = log_tap(now);
                    end
                end
            end
        end else if (primed) begin
            occ_now = (avg_acc >= {occ_thr_q, 16'h0});
            if (occ_now != occ_flag) begin
                occ_flag = occ_now;
                word.changed = 1'b1;
            end
        end
        word.occupied = occ_flag;
        word.average = avg_acc[ACC_W-1:16];
        return word;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_detector_word want;
        if (!i_rst_n) begin
            factor_q   = RST_AVERAGE_FACTOR;
            tap_thr_q  = RST_TAP_THRESHOLD;
            debounce_q = RST_DEBOUNCE_TICKS;
            window_q   = RST_TAP_WINDOW_TICKS;
            occ_thr_q  = RST_OCCUPANCY_THRESHOLD;
            avg_acc    = '0;
            primed     = 1'b0;
            occ_flag   = 1'b0;
            last_tap   = '0;
            ring_fill  = '0;
            ring_wr    = '0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                tap_ring[i] = '0;
            end
            expected_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with nothing expected, average actual %0d",
                             $time, i_average_force);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("tap_detected", 32'(want.tap), 32'(i_tap_detected));
                    check_field("help_event", 32'(want.help), 32'(i_help_event));
                    check_field("occupied", 32'(want.occupied), 32'(i_occupied));
                    check_field("occupancy_changed", 32'(want.changed),
                                32'(i_occupancy_changed));
                    check_field("average_force", 32'(want.average), 32'(i_average_force));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_AVERAGE_FACTOR:      factor_q   = i_cfg_data[FACTOR_W-1:0];
                    REG_TAP_THRESHOLD:       tap_thr_q  = i_cfg_data[FORCE_W-1:0];
                    REG_DEBOUNCE_TICKS:      debounce_q = i_cfg_data[TICKS_W-1:0];
                    REG_TAP_WINDOW_TICKS:    window_q   = i_cfg_data[TICKS_W-1:0];
                    REG_OCCUPANCY_THRESHOLD: occ_thr_q  = i_cfg_data[FORCE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_words.push_back(predict_detector(i_kind, i_force_req, i_now_ticks));
            end
        end
        o_pending    <= 32'(expected_words.size());
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for ema_tap_and_occupancy_detector_core: clock, reset, register writes,
// stimulus words and random idling on both channels. Result checking is in ematod_checker.
// Depends on ematod_pkg, ematod_tb_pkg and ematod_checker.
module tb;
    import ematod_pkg::*;
    import ematod_tb_pkg::*;

    localparam int unsigned NUM_TAPS    = 3;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned PHASES      = 13;
    localparam int unsigned PHASE_WORDS = 150;

    localparam logic [FORCE_W-1:0]   FORCE_MAX = '1;
    localparam logic [TICKS_W-1:0]   TICKS_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST =
        CFG_IDX_W'(REG_OCCUPANCY_THRESHOLD + 1);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_kind = 1'b0;
    logic [FORCE_W-1:0]    i_force_req = '0;
    logic [TICKS_W-1:0]    i_now_ticks = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_tap_detected;
    logic                  o_help_event;
    logic                  o_occupied;
    logic                  o_occupancy_changed;
    logic [FORCE_W-1:0]    o_average_force;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [31:0]           pending;
    logic [31:0]           mismatches;
    int unsigned           cycles = 0;
    int unsigned           stall_left = 0;
    logic                  calm = 1'b0;

    always #5 i_clk = ~i_clk;

    ema_tap_and_occupancy_detector_core #(
        .NUM_TAPS(NUM_TAPS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_force_req(i_force_req),
        .i_now_ticks(i_now_ticks),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_tap_detected(o_tap_detected),
        .o_help_event(o_help_event),
        .o_occupied(o_occupied),
        .o_occupancy_changed(o_occupancy_changed),
        .o_average_force(o_average_force),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    ematod_checker #(
        .NUM_TAPS(NUM_TAPS)
    ) u_chk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_force_req(i_force_req),
        .i_now_ticks(i_now_ticks),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_tap_detected(o_tap_detected),
        .i_help_event(o_help_event),
        .i_occupied(o_occupied),
        .i_occupancy_changed(o_occupancy_changed),
        .i_average_force(o_average_force),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_pending(pending),
        .o_mismatches(mismatches)
    );

    // Mostly no gap, sometimes a short one, rarely a long one; none in a calm stretch.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FORCE_W-1:0] clamp_force(input int value);
        if (value < 0) begin
            return '0;
        end
        if (value > int'(FORCE_MAX)) begin
            return FORCE_MAX;
        end
        return value[FORCE_W-1:0];
    endfunction

    task automatic send_word(input t_item_kind kind, input logic [FORCE_W-1:0] force_val,
                             input logic [TICKS_W-1:0] ticks);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_force_req <= force_val;
        i_now_ticks <= ticks;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // The extra edge lets the count include a word accepted at the last edge.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int unsigned hold;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            hold = pick_gap();
            stall_left <= hold;
            i_out_ready <= (hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned         phase;
        int unsigned         n;
        int unsigned         roll;
        int                  base;
        logic [FACTOR_W-1:0] factor;
        logic [FORCE_W-1:0]  tap_thr;
        logic [FORCE_W-1:0]  occ_thr;
        logic [TICKS_W-1:0]  debounce;
        logic [TICKS_W-1:0]  window;
        logic [TICKS_W-1:0]  tick_now;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values.
        send_word(KIND_CHECK, FORCE_MAX, 32'd5);
        send_word(KIND_SAMPLE, 18'd100, 32'd10);
        send_word(KIND_CHECK, 18'd0, 32'd12);
        send_word(KIND_SAMPLE, 18'd0, 32'd11);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'd30);
        send_word(KIND_CHECK, 18'd0, 32'd31);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'd40);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'd60);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'd90);
        // Three taps across the tick wrap.
        send_word(KIND_SAMPLE, FORCE_MAX, 32'hFFFF_FFF0);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'h0000_000C);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'h0000_0028);
        // Taps spread wider than the window.
        send_word(KIND_SAMPLE, FORCE_MAX, 32'h0000_0100);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'h0000_0200);
        send_word(KIND_SAMPLE, FORCE_MAX, 32'h0000_0300);
        send_word(KIND_SAMPLE, 18'd0, TICKS_MAX);
        drain_results();
        write_reg(REG_OCCUPANCY_THRESHOLD, CFG_DATA_W'(FORCE_MAX));
        i_cfg_we <= 1'b0;
        send_word(KIND_CHECK, FORCE_MAX, TICKS_MAX);
        send_word(KIND_SAMPLE, 18'd1, 32'd0);
        send_word(KIND_CHECK, 18'd0, 32'd1);

        tick_now = $urandom();
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            factor   = FACTOR_W'($urandom_range(0, 32768));
            tap_thr  = FORCE_W'($urandom_range(0, 4000));
            debounce = $urandom_range(0, 50);
            window   = $urandom_range(0, 400);
            base     = $urandom_range(0, 40000);
            if ($urandom_range(0, 3) == 0) factor = FACTOR_W'($urandom());
            if ($urandom_range(0, 7) == 0) tap_thr = FORCE_W'($urandom());
            if ($urandom_range(0, 9) == 0) debounce = $urandom();
            if ($urandom_range(0, 9) == 0) window = $urandom();
            if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 32'(FORCE_MAX));
            // Keep the occupancy threshold near the baseline so checks flip the flag.
            occ_thr = clamp_force(base + $urandom_range(0, 6000) - 3000);
            if ($urandom_range(0, 7) == 0) occ_thr = FORCE_W'($urandom());
            case (phase)
                0: begin
                    factor = '0; tap_thr = '0; debounce = '0; window = '0; occ_thr = '0;
                end
                1: begin
                    factor = '1; tap_thr = '1; debounce = '1; window = '1; occ_thr = '1;
                end
                2: begin
                    factor = '1; tap_thr = '0; debounce = '0; window = '1;
                end
                3: begin
                    factor = '0; debounce = '1; window = '0;
                end
                default: ;
            endcase
            write_reg(CFG_IDX_W'(REG_UNUSED_FIRST + $urandom_range(0, 2)), $urandom());
            write_reg(REG_AVERAGE_FACTOR, CFG_DATA_W'(factor));
            write_reg(REG_TAP_THRESHOLD, CFG_DATA_W'(tap_thr));
            write_reg(REG_DEBOUNCE_TICKS, debounce);
            write_reg(REG_TAP_WINDOW_TICKS, window);
            write_reg(REG_OCCUPANCY_THRESHOLD, CFG_DATA_W'(occ_thr));
            i_cfg_we <= 1'b0;

            for (n = 0; n < PHASE_WORDS; n++) begin
                if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll == 0) begin
                    tick_now = TICKS_MAX - $urandom_range(0, 300);
                end else if ($urandom_range(0, 3) != 0) begin
                    tick_now = tick_now + $urandom_range(1, 40);
                end
                if (roll < 8) begin
                    send_word(t_item_kind'($urandom_range(0, 1)), FORCE_W'($urandom()),
                              $urandom());
                end else if (roll < 25) begin
                    send_word(KIND_CHECK, FORCE_W'($urandom()), tick_now);
                end else if (roll < 55) begin
                    send_word(KIND_SAMPLE,
                              clamp_force(base + 2 * tap_thr + $urandom_range(0, 3000)),
                              tick_now);
                end else begin
                    send_word(KIND_SAMPLE, clamp_force(base + $urandom_range(0, 3000) - 1500),
                              tick_now);
                end
            end
        end

        drain_results();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
